@@ design/stok_pkg.sv @@
// Package for the script tokenizer: types, token codes, scan modes and keyword lookup.
// No dependencies; used by stok_outq, script_tokenizer and the testbench.
`default_nettype none
package stok_pkg;

  localparam int KeyBufLen = 16;
  localparam int KeyIdxW   = $clog2(KeyBufLen);
  localparam logic [19:0] LineMax = 20'hFFFFF;
  localparam logic [15:0] ColMax  = 16'hFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_HASH, M_OP, M_STRING, M_ESCAPE,
    M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_WORD, M_SYMBOL
  } mode_t;

  localparam logic [5:0] T_EOF     = 6'd0;
  localparam logic [5:0] T_NEWLINE = 6'd1;
  localparam logic [5:0] T_STRING  = 6'd2;
  localparam logic [5:0] T_NUMBER  = 6'd3;
  localparam logic [5:0] T_SYMBOL  = 6'd4;
  localparam logic [5:0] T_IDENT   = 6'd5;
  localparam logic [5:0] T_KW0     = 6'd6;
  localparam logic [5:0] T_DOT     = 6'd36;
  localparam logic [5:0] T_INTERP  = 6'd55;
  localparam logic [5:0] T_ERROR   = 6'd56;

  // One result of an input item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic [5:0]  token_type;
    logic [19:0] line;
    logic [15:0] column;
  } res_t;

  // Up to three results produced by one transaction.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } res_group_t;

  typedef logic [KeyBufLen-1:0][7:0] kbuf_t;

  function automatic logic [5:0] op_single(input logic [2:0] op);
    logic [5:0] t;
    case (op)
      3'd0: t = 6'd39;
      3'd1: t = 6'd41;
      3'd2: t = 6'd47;
      3'd3: t = 6'd28;
      3'd4: t = 6'd51;
      3'd5: t = 6'd53;
      3'd6: t = 6'd45;
      default: t = 6'd38;
    endcase
    return t;
  endfunction

  function automatic logic ch_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic ch_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // Letters, digits and underscore continue a word.
  function automatic logic ch_wordc(input logic [7:0] c);
    return ch_letter(c) || ch_digit(c);
  endfunction

  function automatic logic kw_eq(input kbuf_t b, input logic [4:0] len,
                                 input logic [14*8-1:0] txt, input int n);
    logic ok;
    ok = (len == 5'(n));
    for (int i = 0; i < 14; i++) begin
      if (i < n && i < KeyBufLen) begin
        if (b[i] != txt[(n-1-i)*8 +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [5:0] word_type(input kbuf_t b, input logic [4:0] len);
    logic [5:0] t;
    t = T_IDENT;
    if (kw_eq(b, len, 112'("project"), 7))                t = 6'd6;
    if (kw_eq(b, len, 112'("executable"), 10))            t = 6'd7;
    if (kw_eq(b, len, 112'("library"), 7))                t = 6'd8;
    if (kw_eq(b, len, 112'({"shared", "_library"}), 14))  t = 6'd9;
    if (kw_eq(b, len, 112'({"static", "_library"}), 14))  t = 6'd10;
    if (kw_eq(b, len, 112'("compiler"), 8))               t = 6'd11;
    if (kw_eq(b, len, 112'("dependency"), 10))            t = 6'd12;
    if (kw_eq(b, len, 112'("task"), 4))                   t = 6'd13;
    if (kw_eq(b, len, 112'("if"), 2))                     t = 6'd14;
    if (kw_eq(b, len, 112'("else"), 4))                   t = 6'd15;
    if (kw_eq(b, len, 112'("unless"), 6))                 t = 6'd16;
    if (kw_eq(b, len, 112'("for"), 3))                    t = 6'd17;
    if (kw_eq(b, len, 112'("in"), 2))                     t = 6'd18;
    if (kw_eq(b, len, 112'("do"), 2))                     t = 6'd19;
    if (kw_eq(b, len, 112'("end"), 3))                    t = 6'd20;
    if (kw_eq(b, len, 112'("fn"), 2))                     t = 6'd21;
    if (kw_eq(b, len, 112'("return"), 6))                 t = 6'd22;
    if (kw_eq(b, len, 112'("true"), 4))                   t = 6'd23;
    if (kw_eq(b, len, 112'("false"), 5))                  t = 6'd24;
    if (kw_eq(b, len, 112'("nil"), 3))                    t = 6'd25;
    if (kw_eq(b, len, 112'("and"), 3))                    t = 6'd26;
    if (kw_eq(b, len, 112'("or"), 2))                     t = 6'd27;
    if (kw_eq(b, len, 112'("not"), 3))                    t = 6'd28;
    return t;
  endfunction

endpackage
`default_nettype wire

@@ design/stok_outq.sv @@
// Output queue for the script tokenizer: holds result groups and serializes them.
// Depends on stok_pkg.
`default_nettype none
module stok_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire stok_pkg::res_group_t  grp,
  output logic                       can_push,
  output logic                       valid,
  input  wire logic                  stall,
  output logic                       kind,
  output logic [7:0]                 value_byte,
  output logic [5:0]                 token_type,
  output logic [19:0]                line,
  output logic [15:0]                column,
  output logic                       last
);
  // Two group slots; the head group is drained one result per transaction.
  stok_pkg::res_group_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] used;
  logic [1:0] sub;
  stok_pkg::res_t cur;
  logic pop_res, pop_grp;

  assign can_push = (used != 2'd2);
  assign valid    = (used != 2'd0);

  always_comb begin
    case (sub)
      2'd0: cur = slot[rd_ptr].r0;
      2'd1: cur = slot[rd_ptr].r1;
      default: cur = slot[rd_ptr].r2;
    endcase
  end

  assign kind       = cur.kind;
  assign value_byte = cur.value_byte;
  assign token_type = cur.token_type;
  assign line       = cur.line;
  assign column     = cur.column;
  assign last       = (sub == slot[rd_ptr].count - 2'd1);

  assign pop_res = valid && !stall;
  assign pop_grp = pop_res && last;

  always_ff @(posedge clk) begin
    if (push && can_push) slot[wr_ptr] <= grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
      sub    <= 2'd0;
    end else begin
      if (push && can_push) wr_ptr <= ~wr_ptr;
      if (pop_grp) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 2'd0;
      end else if (pop_res) begin
        sub <= sub + 2'd1;
      end
      used <= used + {1'b0, push && can_push} - {1'b0, pop_grp};
    end
  end
endmodule
`default_nettype wire

@@ design/script_tokenizer.sv @@
// Script tokenizer top level: scan state, lexing logic and the output queue.
// Depends on stok_pkg and stok_outq.
//
// Usage: source bytes enter on the input channel (in_byte, end_of_input, valid/stall),
// one byte per transaction. Each transaction yields zero to three results on the
// output channel (kind, value_byte, token_type, line, column, last). Value bytes come
// before the token they belong to; last marks the final result of one input byte.
// Some bytes, such as blanks in idle, comment text and opening quotes, give no result at all.
// Scanning: an accepted byte is scanned in the cycle it arrives and its result group
// is registered into a two-group output queue, from which the results are read out.
// Throughput: one input byte per cycle while the queue has room; a group of three
// results takes three output transactions, so sustained bursts of such groups
// stall the input until the queue drains.
// Reset (rst, synchronous) returns the scanner to idle at line 1, column 1 and
// empties the queue. End of input flushes any pending token, emits EOF and also
// returns the scanner to that state. When the receiver stalls, the head result
// holds steady and in_stall rises once both queue slots are full.
`default_nettype none
module script_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       value_byte,
  output logic [5:0]       token_type,
  output logic [19:0]      line,
  output logic [15:0]      column,
  output logic             last
);
  stok_pkg::mode_t mode, mode_next;
  logic        quote_single, quote_single_next;
  stok_pkg::kbuf_t kbuf;
  logic [4:0]  wlen, wlen_next;
  logic [19:0] line_count, line_count_next;
  logic [15:0] column_count, column_count_next;
  logic [19:0] held_line, held_line_next;
  logic [15:0] held_column, held_column_next;
  logic [2:0]  held_op, held_op_next;
  logic        kb_we;
  logic [stok_pkg::KeyIdxW-1:0] kb_idx;

  stok_pkg::res_group_t grp;
  logic can_push, accept;

  assign in_stall = !can_push;
  assign accept   = in_valid && can_push;

  // Position after the current byte is consumed (computed once, used where needed).
  logic [19:0] ln_adv;
  logic [15:0] col_adv;
  always_comb begin
    ln_adv  = line_count;
    col_adv = column_count;
    if (in_byte == 8'h0A) begin
      if (line_count != stok_pkg::LineMax) ln_adv = line_count + 20'd1;
      col_adv = 16'd1;
    end else if (column_count != stok_pkg::ColMax) begin
      col_adv = column_count + 16'd1;
    end
  end

  // Fresh-start handling of a byte from idle; position is supplied by caller.
  typedef struct packed {
    stok_pkg::mode_t mode;
    logic       consume;
    logic       tok;
    logic [5:0] ttype;
    logic       val;
    logic       set_op;
    logic [2:0] op;
    logic       set_quote;
    logic       word_start;
  } idle_t;

  idle_t idl;
  always_comb begin
    idl = '0;
    idl.mode = stok_pkg::M_IDLE;
    idl.consume = 1'b1;
    case (in_byte)
      " ", 8'h09, 8'h0D: ;
      8'h0A: begin idl.tok = 1'b1; idl.ttype = stok_pkg::T_NEWLINE; end
      "#": idl.mode = stok_pkg::M_HASH;
      8'h22, 8'h27: begin idl.mode = stok_pkg::M_STRING; idl.set_quote = 1'b1; end
      "+": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd0; end
      "-": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd1; end
      "=": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd2; end
      "!": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd3; end
      "<": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd4; end
      ">": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd5; end
      "/": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd6; end
      ":": begin idl.mode = stok_pkg::M_OP; idl.set_op = 1'b1; idl.op = 3'd7; end
      "(": begin idl.tok = 1'b1; idl.ttype = 6'd29; end
      ")": begin idl.tok = 1'b1; idl.ttype = 6'd30; end
      "[": begin idl.tok = 1'b1; idl.ttype = 6'd31; end
      "]": begin idl.tok = 1'b1; idl.ttype = 6'd32; end
      "{": begin idl.tok = 1'b1; idl.ttype = 6'd33; end
      "}": begin idl.tok = 1'b1; idl.ttype = 6'd34; end
      ",": begin idl.tok = 1'b1; idl.ttype = 6'd35; end
      ".": begin idl.tok = 1'b1; idl.ttype = stok_pkg::T_DOT; end
      ";": begin idl.tok = 1'b1; idl.ttype = 6'd37; end
      "*": begin idl.tok = 1'b1; idl.ttype = 6'd44; end
      "%": begin idl.tok = 1'b1; idl.ttype = 6'd46; end
      default: begin
        if (stok_pkg::ch_digit(in_byte)) begin
          idl.mode = stok_pkg::M_NUM_INT; idl.val = 1'b1;
        end else if (stok_pkg::ch_letter(in_byte)) begin
          idl.mode = stok_pkg::M_WORD; idl.val = 1'b1; idl.word_start = 1'b1;
        end
      end
    endcase
  end

  // Main scan: builds the result group and the next state.
  logic [5:0] wtype;
  assign wtype = stok_pkg::word_type(kbuf, wlen);

  always_comb begin
    stok_pkg::res_t vres, tres;
    logic run_idle;
    logic is_w;
    logic [7:0] ev;
    mode_next         = mode;
    quote_single_next = quote_single;
    wlen_next         = wlen;
    line_count_next   = line_count;
    column_count_next = column_count;
    held_line_next    = held_line;
    held_column_next  = held_column;
    held_op_next      = held_op;
    kb_we    = 1'b0;
    kb_idx   = wlen[stok_pkg::KeyIdxW-1:0];
    grp      = '0;
    run_idle = 1'b0;
    is_w     = stok_pkg::ch_wordc(in_byte);
    ev       = in_byte;
    vres     = '0;
    tres     = '0;

    if (end_of_input) begin
      tres.kind = 1'b1; tres.line = line_count; tres.column = column_count;
      case (mode)
        stok_pkg::M_OP: begin
          tres.token_type = stok_pkg::op_single(held_op);
          grp.r0 = tres; grp.count = 2'd1;
        end
        stok_pkg::M_STRING, stok_pkg::M_ESCAPE: begin
          tres.token_type = stok_pkg::T_ERROR; grp.r0 = tres; grp.count = 2'd1;
        end
        stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC: begin
          tres.token_type = stok_pkg::T_NUMBER; grp.r0 = tres; grp.count = 2'd1;
        end
        stok_pkg::M_NUM_DOT: begin
          grp.r0 = '{kind: 1'b1, value_byte: 8'd0, token_type: stok_pkg::T_NUMBER,
                     line: held_line, column: held_column};
          tres.token_type = stok_pkg::T_DOT; grp.r1 = tres; grp.count = 2'd2;
        end
        stok_pkg::M_WORD: begin
          tres.token_type = wtype; grp.r0 = tres; grp.count = 2'd1;
        end
        stok_pkg::M_SYMBOL: begin
          tres.token_type = stok_pkg::T_SYMBOL; grp.r0 = tres; grp.count = 2'd1;
        end
        default: ;
      endcase
      tres.token_type = stok_pkg::T_EOF;
      case (grp.count)
        2'd0: grp.r0 = tres;
        2'd1: grp.r1 = tres;
        default: grp.r2 = tres;
      endcase
      grp.count = grp.count + 2'd1;
      mode_next = stok_pkg::M_IDLE; quote_single_next = 1'b0; wlen_next = 5'd0;
      line_count_next = 20'd1; column_count_next = 16'd1;
      held_line_next = 20'd1; held_column_next = 16'd1; held_op_next = 3'd0;
    end else begin
      // Token closed by lookahead, at the position before this byte.
      tres.kind = 1'b1; tres.line = line_count; tres.column = column_count;
      case (mode)
        stok_pkg::M_COMMENT: begin
          if (in_byte == 8'h0A) run_idle = 1'b1;
          else begin line_count_next = ln_adv; column_count_next = col_adv; end
        end
        stok_pkg::M_HASH: begin
          if (in_byte == "{") begin
            line_count_next = ln_adv; column_count_next = col_adv;
            grp.r0 = '{kind: 1'b1, value_byte: 8'd0, token_type: stok_pkg::T_INTERP,
                       line: ln_adv, column: col_adv};
            grp.count = 2'd1; mode_next = stok_pkg::M_IDLE;
          end else if (in_byte == 8'h0A) run_idle = 1'b1;
          else begin
            mode_next = stok_pkg::M_COMMENT;
            line_count_next = ln_adv; column_count_next = col_adv;
          end
        end
        stok_pkg::M_OP: begin
          logic [5:0] t2;
          t2 = 6'd0;
          case (held_op)
            3'd0: if (in_byte == "=") t2 = 6'd40;
            3'd1: if (in_byte == ">") t2 = 6'd42; else if (in_byte == "=") t2 = 6'd43;
            3'd2: if (in_byte == "=") t2 = 6'd48; else if (in_byte == ">") t2 = 6'd49;
            3'd3: if (in_byte == "=") t2 = 6'd50;
            3'd4: if (in_byte == "=") t2 = 6'd52;
            3'd5: if (in_byte == "=") t2 = 6'd54;
            default: ;
          endcase
          if (held_op == 3'd6 && in_byte == "/") begin
            mode_next = stok_pkg::M_COMMENT;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else if (held_op == 3'd7 && stok_pkg::ch_letter(in_byte)) begin
            mode_next = stok_pkg::M_SYMBOL;
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else if (t2 != 6'd0) begin
            line_count_next = ln_adv; column_count_next = col_adv;
            grp.r0 = '{kind: 1'b1, value_byte: 8'd0, token_type: t2,
                       line: ln_adv, column: col_adv};
            grp.count = 2'd1; mode_next = stok_pkg::M_IDLE;
          end else begin
            tres.token_type = stok_pkg::op_single(held_op);
            grp.r0 = tres; grp.count = 2'd1; run_idle = 1'b1;
          end
        end
        stok_pkg::M_STRING: begin
          line_count_next = ln_adv; column_count_next = col_adv;
          if (in_byte == (quote_single ? 8'h27 : 8'h22)) begin
            grp.r0 = '{kind: 1'b1, value_byte: 8'd0, token_type: stok_pkg::T_STRING,
                       line: ln_adv, column: col_adv};
            grp.count = 2'd1; mode_next = stok_pkg::M_IDLE;
          end else if (in_byte == 8'h5C) begin
            mode_next = stok_pkg::M_ESCAPE;
          end else begin
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
          end
        end
        stok_pkg::M_ESCAPE: begin
          case (in_byte)
            "n": ev = 8'h0A;
            "t": ev = 8'h09;
            "r": ev = 8'h0D;
            default: ev = in_byte;
          endcase
          vres.value_byte = ev; grp.r0 = vres; grp.count = 2'd1;
          line_count_next = ln_adv; column_count_next = col_adv;
          mode_next = stok_pkg::M_STRING;
        end
        stok_pkg::M_NUM_INT: begin
          if (stok_pkg::ch_digit(in_byte)) begin
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else if (in_byte == ".") begin
            held_line_next = line_count; held_column_next = column_count;
            line_count_next = ln_adv; column_count_next = col_adv;
            mode_next = stok_pkg::M_NUM_DOT;
          end else begin
            tres.token_type = stok_pkg::T_NUMBER; grp.r0 = tres; grp.count = 2'd1;
            run_idle = 1'b1;
          end
        end
        stok_pkg::M_NUM_DOT: begin
          if (stok_pkg::ch_digit(in_byte)) begin
            vres.value_byte = "."; grp.r0 = vres;
            vres.value_byte = in_byte; grp.r1 = vres; grp.count = 2'd2;
            line_count_next = ln_adv; column_count_next = col_adv;
            mode_next = stok_pkg::M_NUM_FRAC;
          end else begin
            grp.r0 = '{kind: 1'b1, value_byte: 8'd0, token_type: stok_pkg::T_NUMBER,
                       line: held_line, column: held_column};
            tres.token_type = stok_pkg::T_DOT; grp.r1 = tres; grp.count = 2'd2;
            run_idle = 1'b1;
          end
        end
        stok_pkg::M_NUM_FRAC: begin
          if (stok_pkg::ch_digit(in_byte)) begin
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else begin
            tres.token_type = stok_pkg::T_NUMBER; grp.r0 = tres; grp.count = 2'd1;
            run_idle = 1'b1;
          end
        end
        stok_pkg::M_WORD: begin
          if (is_w) begin
            kb_we = ({1'b0, wlen} < 6'(stok_pkg::KeyBufLen));
            if (wlen != 5'd31) wlen_next = wlen + 5'd1;
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else begin
            tres.token_type = wtype; grp.r0 = tres; grp.count = 2'd1;
            run_idle = 1'b1;
          end
        end
        stok_pkg::M_SYMBOL: begin
          if (is_w) begin
            vres.value_byte = in_byte; grp.r0 = vres; grp.count = 2'd1;
            line_count_next = ln_adv; column_count_next = col_adv;
          end else begin
            tres.token_type = stok_pkg::T_SYMBOL; grp.r0 = tres; grp.count = 2'd1;
            run_idle = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        stok_pkg::res_t ir;
        ir = '0;
        mode_next = idl.mode;
        line_count_next = ln_adv; column_count_next = col_adv;
        if (idl.set_op) held_op_next = idl.op;
        if (idl.set_quote) quote_single_next = (in_byte == 8'h27);
        if (idl.word_start) begin
          wlen_next = 5'd1; kb_we = 1'b1; kb_idx = '0;
        end
        if (idl.tok) begin
          ir.kind = 1'b1; ir.token_type = idl.ttype;
          ir.line = ln_adv; ir.column = col_adv;
        end else begin
          ir.value_byte = in_byte;
        end
        if (idl.tok || idl.val) begin
          if (grp.count == 2'd0) grp.r0 = ir;
          else if (grp.count == 2'd1) grp.r1 = ir;
          else grp.r2 = ir;
          grp.count = grp.count + 2'd1;
        end
      end
    end
  end

  // Keyword buffer: entries beyond the current word may be read but never decide a match.
  always_ff @(posedge clk) begin
    if (accept && kb_we) kbuf[kb_idx] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= stok_pkg::M_IDLE;
      quote_single <= 1'b0;
      wlen         <= 5'd0;
      line_count   <= 20'd1;
      column_count <= 16'd1;
      held_line    <= 20'd1;
      held_column  <= 16'd1;
      held_op      <= 3'd0;
    end else if (accept) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      wlen         <= wlen_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      held_line    <= held_line_next;
      held_column  <= held_column_next;
      held_op      <= held_op_next;
    end
  end

  stok_outq u_outq (
    .clk(clk), .rst(rst),
    .push(accept && grp.count != 2'd0), .grp(grp), .can_push(can_push),
    .valid(out_valid), .stall(out_stall),
    .kind(kind), .value_byte(value_byte), .token_type(token_type),
    .line(line), .column(column), .last(last)
  );
endmodule
`default_nettype wire

@@ design/stok_checker.sv @@
// Port-level checker for the script tokenizer, bound to the top level.
// Depends on script_tokenizer ports only.
`default_nettype none
module stok_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        kind,
  input wire logic [7:0]  value_byte,
  input wire logic [5:0]  token_type,
  input wire logic [19:0] line,
  input wire logic [15:0] column,
  input wire logic        last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_type) && $stable(value_byte))
    else $error("stalled result changed");
  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> token_type == 6'd0 && line == 20'd0 && column == 16'd0)
    else $error("value result carries token fields");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> line != 20'd0 && column != 16'd0)
    else $error("token position zero");
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && token_type == 6'd0 |-> last)
    else $error("EOF not last");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind script_tokenizer stok_checker u_stok_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .kind(kind), .value_byte(value_byte), .token_type(token_type),
  .line(line), .column(column), .last(last)
);
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the script tokenizer: drives source bytes and checks every result.
// Depends on stok_pkg and the script_tokenizer design; needs no files or arguments.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int NumRandom = 190;
  localparam int MaxErrShown = 10;

  // A source transaction as the driver sees it.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } src_item_t;

  // One expected output transaction.
  typedef struct {
    logic        kind;
    logic [7:0]  vbyte;
    logic [5:0]  ttype;
    logic [19:0] ln;
    logic [15:0] col;
    logic        lst;
  } tok_res_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic [7:0]  value_byte;
  logic [5:0]  token_type;
  logic [19:0] line;
  logic [15:0] column;
  logic        last;

  script_tokenizer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .value_byte(value_byte), .token_type(token_type),
    .line(line), .column(column), .last(last)
  );

  src_item_t pending_src[$];
  tok_res_t  expected_tokens[$];
  int        mismatch_count = 0;
  bit        stimulus_done = 0;
  bit        hold_off = 0;

  // Private copy of the scanner state used for prediction.
  stok_pkg::mode_t lx_mode;
  logic        lx_single_quote;
  logic [7:0]  lx_word[stok_pkg::KeyBufLen];
  logic [4:0]  lx_word_len;
  logic [19:0] lx_line;
  logic [15:0] lx_col;
  logic [19:0] lx_held_line;
  logic [15:0] lx_held_col;
  logic [2:0]  lx_held_op;
  tok_res_t    lx_group[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic lexer_clear();
    lx_mode = stok_pkg::M_IDLE;
    lx_single_quote = 1'b0;
    lx_word_len = '0;
    lx_line = 20'd1;
    lx_col = 16'd1;
    lx_held_line = 20'd1;
    lx_held_col = 16'd1;
    lx_held_op = '0;
    for (int i = 0; i < stok_pkg::KeyBufLen; i++) lx_word[i] = 8'h00;
  endtask

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // Single-character operator codes, indexed by the held operator.
  function automatic logic [5:0] lone_op_code(logic [2:0] op);
    logic [5:0] codes[8];
    codes = '{6'd39, 6'd41, 6'd47, 6'd28, 6'd51, 6'd53, 6'd45, 6'd38};
    return codes[op];
  endfunction

  // Keyword lookup over the characters collected for the current word.
  function automatic logic [5:0] classify_word();
    string kws[23];
    bit    hit;
    kws = '{"project", "executable", "library", string'({"shared", "_library"}),
            string'({"static", "_library"}),
            "compiler", "dependency", "task", "if", "else", "unless", "for", "in",
            "do", "end", "fn", "return", "true", "false", "nil", "and", "or", "not"};
    if (lx_word_len > stok_pkg::KeyBufLen) return stok_pkg::T_IDENT;
    for (int k = 0; k < 23; k++) begin
      if (kws[k].len() == lx_word_len) begin
        hit = 1;
        for (int i = 0; i < kws[k].len(); i++)
          if (lx_word[i] != kws[k][i]) hit = 0;
        if (hit) return stok_pkg::T_KW0 + 6'(k);
      end
    end
    return stok_pkg::T_IDENT;
  endfunction

  task automatic add_res(logic k, logic [7:0] v, logic [5:0] t, logic [19:0] l,
                         logic [15:0] c);
    tok_res_t r;
    r.kind = k; r.vbyte = v; r.ttype = t; r.ln = l; r.col = c; r.lst = 1'b0;
    lx_group = {lx_group, r};
  endtask

  task automatic add_value(logic [7:0] v);
    add_res(1'b0, v, 6'd0, 20'd0, 16'd0);
  endtask

  task automatic add_token(logic [5:0] t);
    add_res(1'b1, 8'h00, t, lx_line, lx_col);
  endtask

  task automatic advance_pos(logic [7:0] c);
    if (c == 8'h0A) begin
      if (lx_line != stok_pkg::LineMax) lx_line++;
      lx_col = 16'd1;
    end else if (lx_col != stok_pkg::ColMax) begin
      lx_col++;
    end
  endtask

  task automatic word_append(logic [7:0] c);
    if (lx_word_len < stok_pkg::KeyBufLen) lx_word[lx_word_len] = c;
    if (lx_word_len < 5'd31) lx_word_len++;
  endtask

  task automatic hold_op(logic [2:0] op, logic [7:0] c);
    lx_held_op = op;
    lx_mode = stok_pkg::M_OP;
    advance_pos(c);
  endtask

  // A byte seen with nothing pending: it may start a token or be dropped.
  task automatic scan_fresh(logic [7:0] c);
    logic [5:0] t;
    t = 6'd0;
    lx_mode = stok_pkg::M_IDLE;
    case (c)
      " ", 8'h09, 8'h0D: begin advance_pos(c); return; end
      8'h0A: begin advance_pos(c); add_token(stok_pkg::T_NEWLINE); return; end
      "#": begin lx_mode = stok_pkg::M_HASH; advance_pos(c); return; end
      8'h22, 8'h27: begin
        lx_single_quote = (c == 8'h27);
        lx_mode = stok_pkg::M_STRING;
        advance_pos(c);
        return;
      end
      "+": begin hold_op(3'd0, c); return; end
      "-": begin hold_op(3'd1, c); return; end
      "=": begin hold_op(3'd2, c); return; end
      "!": begin hold_op(3'd3, c); return; end
      "<": begin hold_op(3'd4, c); return; end
      ">": begin hold_op(3'd5, c); return; end
      "/": begin hold_op(3'd6, c); return; end
      ":": begin hold_op(3'd7, c); return; end
      "(": t = 6'd29;
      ")": t = 6'd30;
      "[": t = 6'd31;
      "]": t = 6'd32;
      "{": t = 6'd33;
      "}": t = 6'd34;
      ",": t = 6'd35;
      ".": t = stok_pkg::T_DOT;
      ";": t = 6'd37;
      "*": t = 6'd44;
      "%": t = 6'd46;
      default: t = 6'd0;
    endcase
    if (t != 6'd0) begin
      advance_pos(c);
      add_token(t);
    end else if (digit_ch(c)) begin
      lx_mode = stok_pkg::M_NUM_INT;
      add_value(c);
      advance_pos(c);
    end else if (alpha_ch(c)) begin
      lx_mode = stok_pkg::M_WORD;
      lx_word_len = '0;
      word_append(c);
      add_value(c);
      advance_pos(c);
    end else begin
      advance_pos(c);
    end
  endtask

  // Second character of a possible two-character operator.
  task automatic scan_op(logic [7:0] c);
    logic [5:0] t;
    t = 6'd0;
    case (lx_held_op)
      3'd0: if (c == "=") t = 6'd40;
      3'd1: if (c == ">") t = 6'd42; else if (c == "=") t = 6'd43;
      3'd2: if (c == "=") t = 6'd48; else if (c == ">") t = 6'd49;
      3'd3: if (c == "=") t = 6'd50;
      3'd4: if (c == "=") t = 6'd52;
      3'd5: if (c == "=") t = 6'd54;
      3'd6: if (c == "/") begin
        lx_mode = stok_pkg::M_COMMENT;
        advance_pos(c);
        return;
      end
      default: if (alpha_ch(c)) begin
        lx_mode = stok_pkg::M_SYMBOL;
        add_value(c);
        advance_pos(c);
        return;
      end
    endcase
    if (t != 6'd0) begin
      advance_pos(c);
      add_token(t);
      lx_mode = stok_pkg::M_IDLE;
    end else begin
      add_token(lone_op_code(lx_held_op));
      scan_fresh(c);
    end
  endtask

  // Predicts the results of one accepted transaction and queues them.
  task automatic predict_tokens(src_item_t it);
    logic [7:0] c;
    logic [7:0] v;
    c = it.ch;
    lx_group.delete();
    if (it.eoi) begin
      case (lx_mode)
        stok_pkg::M_OP: add_token(lone_op_code(lx_held_op));
        stok_pkg::M_STRING, stok_pkg::M_ESCAPE: add_token(stok_pkg::T_ERROR);
        stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC: add_token(stok_pkg::T_NUMBER);
        stok_pkg::M_NUM_DOT: begin
          add_res(1'b1, 8'h00, stok_pkg::T_NUMBER, lx_held_line, lx_held_col);
          add_token(stok_pkg::T_DOT);
        end
        stok_pkg::M_WORD: add_token(classify_word());
        stok_pkg::M_SYMBOL: add_token(stok_pkg::T_SYMBOL);
        default: ;
      endcase
      add_token(stok_pkg::T_EOF);
      lexer_clear();
    end else begin
      case (lx_mode)
        stok_pkg::M_COMMENT: if (c == 8'h0A) scan_fresh(c); else advance_pos(c);
        stok_pkg::M_HASH: begin
          if (c == "{") begin
            advance_pos(c);
            add_token(stok_pkg::T_INTERP);
            lx_mode = stok_pkg::M_IDLE;
          end else begin
            lx_mode = stok_pkg::M_COMMENT;
            if (c == 8'h0A) scan_fresh(c); else advance_pos(c);
          end
        end
        stok_pkg::M_OP: scan_op(c);
        stok_pkg::M_STRING: begin
          if (c == (lx_single_quote ? 8'h27 : 8'h22)) begin
            advance_pos(c);
            add_token(stok_pkg::T_STRING);
            lx_mode = stok_pkg::M_IDLE;
          end else if (c == 8'h5C) begin
            advance_pos(c);
            lx_mode = stok_pkg::M_ESCAPE;
          end else begin
            add_value(c);
            advance_pos(c);
          end
        end
        stok_pkg::M_ESCAPE: begin
          v = c;
          if (c == "n") v = 8'h0A;
          else if (c == "t") v = 8'h09;
          else if (c == "r") v = 8'h0D;
          add_value(v);
          advance_pos(c);
          lx_mode = stok_pkg::M_STRING;
        end
        stok_pkg::M_NUM_INT: begin
          if (digit_ch(c)) begin
            add_value(c);
            advance_pos(c);
          end else if (c == ".") begin
            lx_held_line = lx_line;
            lx_held_col = lx_col;
            advance_pos(c);
            lx_mode = stok_pkg::M_NUM_DOT;
          end else begin
            add_token(stok_pkg::T_NUMBER);
            scan_fresh(c);
          end
        end
        stok_pkg::M_NUM_DOT: begin
          if (digit_ch(c)) begin
            add_value(".");
            add_value(c);
            advance_pos(c);
            lx_mode = stok_pkg::M_NUM_FRAC;
          end else begin
            add_res(1'b1, 8'h00, stok_pkg::T_NUMBER, lx_held_line, lx_held_col);
            add_token(stok_pkg::T_DOT);
            scan_fresh(c);
          end
        end
        stok_pkg::M_NUM_FRAC: begin
          if (digit_ch(c)) begin
            add_value(c);
            advance_pos(c);
          end else begin
            add_token(stok_pkg::T_NUMBER);
            scan_fresh(c);
          end
        end
        stok_pkg::M_WORD: begin
          if (alpha_ch(c) || digit_ch(c)) begin
            word_append(c);
            add_value(c);
            advance_pos(c);
          end else begin
            add_token(classify_word());
            scan_fresh(c);
          end
        end
        stok_pkg::M_SYMBOL: begin
          if (alpha_ch(c) || digit_ch(c)) begin
            add_value(c);
            advance_pos(c);
          end else begin
            add_token(stok_pkg::T_SYMBOL);
            scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (lx_group.size() > 0) lx_group[lx_group.size()-1].lst = 1'b1;
    expected_tokens = {expected_tokens, lx_group};
  endtask

  // Stimulus helpers: queue raw text, a single byte, or an end-of-input mark.
  task automatic queue_byte(logic [7:0] c);
    src_item_t it;
    it.ch = c;
    it.eoi = 1'b0;
    pending_src = {pending_src, it};
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_eoi();
    src_item_t it;
    it.ch = 8'($urandom);
    it.eoi = 1'b1;
    pending_src = {pending_src, it};
  endtask

  // Random well-formed fragment of script text.
  function automatic string random_fragment();
    string pieces[24];
    string s;
    int    n;
    pieces = '{"project", string'({"shared", "_library"}), string'({"static", "_library"}),
                "foo_1", "x", "12",
                "3.14", "7.", "'a\\tb'", "\"q\\\"z\"", "# note\n", "// c\n", "#{",
                ":sym", "+=", "->", "==", "=>", "!=", "<=", ">=", "!", "(", "\n"};
    s = pieces[$urandom_range(0, 23)];
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 20);
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("a", "z")))};
    end
    return s;
  endfunction

  initial begin
    string frag;
    int    picked;
    lexer_clear();
    // Directed part: every token class, escapes, lookahead cases and end of input
    // inside a string.
    queue_text("if x>=12.5 :ab // c\n");
    queue_text("7.) a.b #{'\\n\\q' \"x\\");
    queue_eoi();
    queue_text("not! - -> -= = => < > / + % * ; , [ ] { } ");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_eoi();
    queue_text("abcdefghijklmnopqrstuvwxyz012345678 3");
    queue_eoi();
    queue_text("12.");
    queue_eoi();
    // Random part: mostly well-formed text, some raw noise.
    picked = 0;
    while (picked < NumRandom) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_byte(8'($urandom));
        picked++;
      end else begin
        frag = random_fragment();
        queue_text(frag);
        queue_byte(($urandom_range(0, 1) == 0) ? " " : 8'h0A);
        picked += frag.len() + 1;
      end
      if ($urandom_range(0, 40) == 0) queue_eoi();
    end
    queue_eoi();
  end

  // Whether the item on the bus was still waiting at the last rising edge.
  logic in_stall_seen;

  // Driver: pops pending bytes, waits a random gap, holds each item until taken.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      end_of_input <= 1'b0;
    end else if (!in_valid || !in_stall_seen) begin
      // The previous item (if any) was accepted at the last rising edge.
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_src.size() > 0) begin
        in_valid <= 1'b1;
        in_byte <= pending_src[0].ch;
        end_of_input <= pending_src[0].eoi;
        pending_src.pop_front();
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      end else begin
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_stall_seen <= 1'b0;
    end else begin
      in_stall_seen <= in_valid && in_stall;
      if (in_valid && !in_stall) begin
        src_item_t it;
        it.ch = in_byte;
        it.eoi = end_of_input;
        predict_tokens(it);
      end
    end
  end

  // Receiver stall: random gaps per result plus one long hold-off window.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && ($urandom_range(0, 2) == 0)) recv_gap <= $urandom_range(0, 6);
    end
  end

  initial begin
    int cnt;
    cnt = 0;
    wait (!rst);
    repeat (60) @(posedge clk);
    hold_off = 1;
    while (cnt < 80) begin
      @(posedge clk);
      cnt++;
    end
    hold_off = 0;
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tok_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxErrShown)
          $display("Unexpected result: kind=%0d byte=%02h type=%0d", kind, value_byte,
                   token_type);
      end else begin
        e = expected_tokens.pop_front();
        if (kind !== e.kind || value_byte !== e.vbyte || token_type !== e.ttype ||
            line !== e.ln || column !== e.col || last !== e.lst) begin
          mismatch_count++;
          if (mismatch_count <= MaxErrShown)
            $display("Mismatch: exp k=%0d b=%02h t=%0d l=%0d c=%0d last=%0d,",
                     e.kind, e.vbyte, e.ttype, e.ln, e.col, e.lst,
                     " got k=%0d b=%02h t=%0d l=%0d c=%0d last=%0d",
                     kind, value_byte, token_type, line, column, last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    end_of_input = 1'b0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done && expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("PASS script_tokenizer");
    end else begin
      $display("FAIL script_tokenizer");
    end
    $finish;
  end

  // Watchdog well above the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL script_tokenizer");
    $finish;
  end

endmodule
`default_nettype wire
